### rtl/aout_pkg.sv
// ----------------------------------------------------------------------------
// aout_pkg: shared types and constants of the alpha outline filter
// Register indexes, field widths, reset values and line buffer layout.
// ----------------------------------------------------------------------------
package aout_pkg;

    // Default number of pixels per row that the line buffer can hold.
    localparam int MAX_WIDTH_DEF = 1024;

    // Largest frame height and the width of a row counter.
    localparam int MAX_ROWS = 4096;
    localparam int ROW_W    = $clog2(MAX_ROWS);

    // Configuration register widths.
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;

    // Pixel width and the window size.
    localparam int PIX_W = 32;
    localparam int WIN_W = 9;

    // One line buffer entry: two opacity bits above one centre row pixel.
    localparam int LB_DATA_W = PIX_W + 2;

    // Register reset values.
    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = CFG_WIDTH_W'(1024);
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = CFG_HEIGHT_W'(1024);
    localparam logic [PIX_W-1:0]        RST_OUTLINE      = '0;
    localparam logic [PIX_W-1:0]        RST_ALPHA_MASK   = 32'hFF00_0000;

    // Item kinds carried in the input tuser bit.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_OUTLINE      = 2'd2,
        CFG_ALPHA_MASK   = 2'd3
    } t_cfg_idx;

endpackage

### rtl/aout_linebuf.sv
// ----------------------------------------------------------------------------
// aout_linebuf: line buffer memory
// One write port and one registered read port; a read that meets a write to
// the same entry in the same cycle returns the newly written data.
// ----------------------------------------------------------------------------
module aout_linebuf #(
    parameter int DEPTH = aout_pkg::MAX_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [aout_pkg::LB_DATA_W-1:0] o_rd_data,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [aout_pkg::LB_DATA_W-1:0] i_wr_data
);

    logic [aout_pkg::LB_DATA_W-1:0] r_mem [DEPTH];
    logic [aout_pkg::LB_DATA_W-1:0] r_q;
    logic [aout_pkg::LB_DATA_W-1:0] r_fwd_data;
    logic                           r_fwd;

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, with the colliding write captured for bypass.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Bypass flag: set when the read hit the entry being written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

### rtl/alpha_outline_3x3.sv
// ----------------------------------------------------------------------------
// alpha_outline_3x3: 3x3 alpha outline filter
// Paints transparent pixels next to opaque ones with the outline color.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_axis channel in raster order; s_axis_tuser[0] set
// marks a drain beat. Each pixel comes back on m_axis one row and one column
// later, so a frame is followed by W+1 drain beats that flush the last
// results; m_axis_tlast marks the frame's final pixel and m_axis_tuser[0]
// marks a painted pixel. Drain beats outside a drain phase are dropped.
// One beat is taken every cycle while s_axis_tready is high; the line
// buffer's single read and write port, with bypass of a same-entry write,
// sets that rate. A releasing beat passes the line buffer read into the
// window stage, then the window update into the output register. When
// m_axis stalls, the output register holds its beat and the beat behind it
// waits in the window stage; s_axis_tready drops only when both are full.
// Reset clears the counters, window and registers to their defaults; line
// buffer contents are not cleared and are never used before being written.
// The user writes configuration on the i_cfg port while idle (not enforced).
// ----------------------------------------------------------------------------
module alpha_outline_3x3 #(
    parameter int MAX_WIDTH = aout_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [aout_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [aout_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // [31:0] pixel_in
    input  logic [0:0]                        s_axis_tuser,  // [0] op
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // [31:0] pixel_out
    output logic [0:0]                        m_axis_tuser,  // [0] is_outline
    output logic                              m_axis_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int MW_W  = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (aout_pkg::CFG_WIDTH_W > MW_W) ? aout_pkg::CFG_WIDTH_W : MW_W;
    localparam int ROW_W = aout_pkg::ROW_W;
    localparam int HW    = aout_pkg::CFG_HEIGHT_W;
    localparam int PW    = aout_pkg::PIX_W;
    localparam int NW    = aout_pkg::WIN_W;
    localparam int LW    = aout_pkg::LB_DATA_W;

    // Configuration registers
    logic [aout_pkg::CFG_WIDTH_W-1:0] r_cfg_width;
    logic [HW-1:0]                    r_cfg_height;
    logic [PW-1:0]                    r_cfg_outline;
    logic [PW-1:0]                    r_cfg_alpha;

    // Position and phase control
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic             r_draining, n_draining;
    logic             r_primed, n_primed;

    // Window stage
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic             r_s1_bit;
    logic [PW-1:0]    r_s1_val;
    logic [COL_W-1:0] r_s1_addr;
    logic [NW-1:0]    r_s1_mask;
    logic             r_s1_last;
    logic [NW-1:0]    r_win;
    logic [PW-1:0]    r_ctr0;

    // Output register
    logic             r_o_valid;
    logic [PW-1:0]    r_o_pix;
    logic             r_o_outline;
    logic             r_o_last;

    // Effective frame size
    logic [WW-1:0]    w_ext, w_eff, wm1;
    logic [HW-1:0]    h_eff;
    logic [ROW_W-1:0] hm1;
    logic             in_col_end, in_row_last, out_col_end, out_row_last;

    // Stage handshake and stage-0 decisions
    logic             out_free, s1_go, in_acc;
    logic             s0_shift, s0_bit, s0_emit, s0_last;
    logic [NW-1:0]    s0_mask;
    logic             opaque;

    // Stage-1 datapath
    logic [LW-1:0]    lb_rd;
    logic [LW-1:0]    lb_wr;
    logic [1:0]       rd_opa;
    logic [NW-1:0]    win_new;
    logic             s1_outline;

    // ------------------------------------------------------------------
    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width   <= aout_pkg::RST_IMAGE_WIDTH;
            r_cfg_height  <= aout_pkg::RST_IMAGE_HEIGHT;
            r_cfg_outline <= aout_pkg::RST_OUTLINE;
            r_cfg_alpha   <= aout_pkg::RST_ALPHA_MASK;
        end else if (i_cfg_we) begin
            case (aout_pkg::t_cfg_idx'(i_cfg_idx))
                aout_pkg::CFG_IMAGE_WIDTH:  r_cfg_width   <= i_cfg_data[aout_pkg::CFG_WIDTH_W-1:0];
                aout_pkg::CFG_IMAGE_HEIGHT: r_cfg_height  <= i_cfg_data[HW-1:0];
                aout_pkg::CFG_OUTLINE:      r_cfg_outline <= i_cfg_data;
                aout_pkg::CFG_ALPHA_MASK:   r_cfg_alpha   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clamp width and height to the supported range.
    always_comb begin
        w_ext = WW'(r_cfg_width);
        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        wm1 = w_eff - WW'(1);

        if (r_cfg_height == '0) begin
            h_eff = HW'(1);
        end else if (r_cfg_height > HW'(aout_pkg::MAX_ROWS)) begin
            h_eff = HW'(aout_pkg::MAX_ROWS);
        end else begin
            h_eff = r_cfg_height;
        end
        hm1 = ROW_W'(h_eff - HW'(1));
    end

    assign in_col_end   = WW'(r_in_col) >= wm1;
    assign in_row_last  = r_in_row >= hm1;
    assign out_col_end  = WW'(r_out_col) >= wm1;
    assign out_row_last = r_out_row >= hm1;

    // ------------------------------------------------------------------
    // Handshake between input, window stage and output register.
    assign out_free      = !r_o_valid || m_axis_tready;
    assign s1_go         = r_s1_valid && (!r_s1_emit || out_free);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign opaque = (r_cfg_alpha == '0) || ((s_axis_tdata & r_cfg_alpha) != '0);

    // Neighbor mask for the next result; window bit 3k+r is column k
    // (right, center, left) and row r (top, middle, bottom).
    always_comb begin
        s0_mask = 9'h1EF;
        if (r_out_col == '0) begin
            s0_mask = s0_mask & ~9'h1C0;
        end
        if (out_col_end) begin
            s0_mask = s0_mask & ~9'h007;
        end
        if (r_out_row == '0) begin
            s0_mask = s0_mask & ~9'h049;
        end
        if (out_row_last) begin
            s0_mask = s0_mask & ~9'h124;
        end
    end

    assign s0_last = out_row_last && out_col_end;

    // Stage 0: decide what the accepted beat does and advance the counters.
    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_draining = r_draining;
        n_primed   = r_primed;
        s0_shift   = 1'b0;
        s0_bit     = 1'b0;
        s0_emit    = 1'b0;
        if (in_acc) begin
            if (s_axis_tuser[0] == aout_pkg::OP_DRAIN || r_draining) begin
                // Drain or drain phase: empty column, only while draining.
                if (r_draining) begin
                    s0_shift = 1'b1;
                    n_in_col = in_col_end ? '0 : r_in_col + COL_W'(1);
                    n_primed = 1'b1;
                end
            end else begin
                s0_shift = 1'b1;
                s0_bit   = opaque;
                if (r_in_row == ROW_W'(1) && r_in_col == '0) begin
                    n_primed = 1'b1;
                end
                if (in_col_end) begin
                    if (in_row_last) begin
                        n_draining = 1'b1;
                        n_in_row   = '0;
                    end else begin
                        n_in_row = r_in_row + ROW_W'(1);
                    end
                    n_in_col = '0;
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
            end

            s0_emit = s0_shift && r_primed;
            if (s0_emit) begin
                if (s0_last) begin
                    // Frame done: return to the start state.
                    n_out_col  = '0;
                    n_out_row  = '0;
                    n_in_col   = '0;
                    n_in_row   = '0;
                    n_draining = 1'b0;
                    n_primed   = 1'b0;
                end else if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_draining <= 1'b0;
            r_primed   <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_draining <= n_draining;
            r_primed   <= n_primed;
        end
    end

    // Stage-1 control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc && s0_shift) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && s0_shift) begin
            r_s1_emit <= s0_emit;
            r_s1_bit  <= s0_bit;
            r_s1_val  <= (s_axis_tuser[0] == aout_pkg::OP_DRAIN || r_draining) ?
                         '0 : s_axis_tdata;
            r_s1_addr <= r_in_col;
            r_s1_mask <= s0_mask;
            r_s1_last <= s0_last;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: read at acceptance, written back when the window advances.
    assign lb_wr = {rd_opa[0], r_s1_bit, r_s1_val};

    aout_linebuf #(
        .DEPTH     (MAX_WIDTH)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc && s0_shift),
        .i_rd_addr (r_in_col),
        .o_rd_data (lb_rd),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (lb_wr)
    );

    // Stage 1: shift the new column into the window and test the center.
    assign rd_opa     = lb_rd[LW-1:PW];
    assign win_new    = {r_win[NW-4:0], r_s1_bit, rd_opa[0], rd_opa[1]};
    assign s1_outline = !win_new[4] && ((win_new & r_s1_mask) != '0);

    // Keeps the newest pixel read back: the center pixel of the next window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_ctr0 <= '0;
        end else if (s1_go) begin
            r_win  <= win_new;
            r_ctr0 <= lb_rd[PW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go && r_s1_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_emit) begin
            r_o_pix     <= s1_outline ? r_cfg_outline : r_ctr0;
            r_o_outline <= s1_outline;
            r_o_last    <= r_s1_last;
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = r_o_pix;
    assign m_axis_tuser[0] = r_o_outline;
    assign m_axis_tlast    = r_o_last;

endmodule

### tb/sv/outline_tb_pkg.sv
// ----------------------------------------------------------------------------
// outline_tb_pkg: prediction and checking for the alpha outline filter
// Holds a bit-exact copy of the filter's window and line buffers, predicts
// the pixel beat that each accepted input beat releases, and compares the
// beats that leave the block against that prediction in order.
// ----------------------------------------------------------------------------
package outline_tb_pkg;

    // One predicted output beat.
    typedef struct packed {
        logic [aout_pkg::PIX_W-1:0] pixel;
        logic                       painted;
        logic                       last;
    } t_painted_beat;

    class outline_scoreboard;

        // Register copies.
        logic [aout_pkg::CFG_WIDTH_W-1:0]  width_reg   = aout_pkg::RST_IMAGE_WIDTH;
        logic [aout_pkg::CFG_HEIGHT_W-1:0] height_reg  = aout_pkg::RST_IMAGE_HEIGHT;
        logic [aout_pkg::PIX_W-1:0]        outline_reg = aout_pkg::RST_OUTLINE;
        logic [aout_pkg::PIX_W-1:0]        mask_reg    = aout_pkg::RST_ALPHA_MASK;

        // Line buffers and the sliding 3x3 window.
        logic [aout_pkg::PIX_W-1:0] row_pixels [aout_pkg::MAX_WIDTH_DEF];
        logic [1:0]                 row_opacity [aout_pkg::MAX_WIDTH_DEF];
        logic [aout_pkg::WIN_W-1:0] win_opacity = '0;
        logic [aout_pkg::PIX_W-1:0] win_pixels [3];

        // Raster positions and phase flags.
        int unsigned in_col = 0;
        int unsigned in_row = 0;
        int unsigned out_col = 0;
        int unsigned out_row = 0;
        bit          draining = 1'b0;
        bit          primed = 1'b0;

        t_painted_beat expected_beats[$];

        int errors = 0;
        int results_seen = 0;
        int painted_seen = 0;
        int frames_done = 0;
        int beats_taken = 0;

        function new();
            foreach (row_pixels[i]) row_pixels[i] = '0;
            foreach (row_opacity[i]) row_opacity[i] = '0;
            foreach (win_pixels[i]) win_pixels[i] = '0;
        endfunction

        function int unsigned cols();
            if (width_reg == 0) return 1;
            if (width_reg > aout_pkg::MAX_WIDTH_DEF) return aout_pkg::MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned rows();
            if (height_reg == 0) return 1;
            if (height_reg > aout_pkg::MAX_ROWS) return aout_pkg::MAX_ROWS;
            return height_reg;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void write_reg(aout_pkg::t_cfg_idx idx,
                                logic [aout_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                aout_pkg::CFG_IMAGE_WIDTH:  width_reg = data[aout_pkg::CFG_WIDTH_W-1:0];
                aout_pkg::CFG_IMAGE_HEIGHT: height_reg = data[aout_pkg::CFG_HEIGHT_W-1:0];
                aout_pkg::CFG_OUTLINE:      outline_reg = data;
                aout_pkg::CFG_ALPHA_MASK:   mask_reg = data;
                default: ;
            endcase
        endfunction

        // Shift one new column into the window and update the line buffers.
        function void push_window_column(logic opaque, logic [aout_pkg::PIX_W-1:0] value);
            int unsigned col;
            logic [1:0]  rd;
            col = in_col % aout_pkg::MAX_WIDTH_DEF;
            rd = row_opacity[col];
            row_opacity[col] = {rd[0], opaque};
            win_opacity = {win_opacity[5:0], opaque, rd[0], rd[1]};
            win_pixels[2] = win_pixels[1];
            win_pixels[1] = win_pixels[0];
            win_pixels[0] = row_pixels[col];
            row_pixels[col] = value;
        endfunction

        // Advance the model by one accepted input beat; queue any result.
        function void take_beat(logic op, logic [aout_pkg::PIX_W-1:0] pix);
            int unsigned   w;
            int unsigned   h;
            bit            emit;
            bit            row_end;
            logic          opaque;
            logic [8:0]    keep;
            t_painted_beat want;
            w = cols();
            h = rows();
            emit = primed;
            beats_taken++;
            if (op == aout_pkg::OP_DRAIN || draining) begin
                // Drains outside the drain phase are dropped.
                if (!draining) return;
                push_window_column(1'b0, '0);
                in_col = (in_col >= w - 1) ? 0 : in_col + 1;
                primed = 1'b1;
            end else begin
                opaque = (mask_reg == 0) || ((pix & mask_reg) != 0);
                row_end = in_col >= w - 1;
                if (in_row == 1 && in_col == 0) primed = 1'b1;
                push_window_column(opaque, pix);
                if (row_end) begin
                    if (in_row >= h - 1) begin
                        draining = 1'b1;
                        in_row = 0;
                    end else begin
                        in_row++;
                    end
                    in_col = 0;
                end else begin
                    in_col++;
                end
            end
            if (!emit) return;

            // Window bit 3k+r: column k right to left, row r top to bottom.
            keep = 9'h1EF;
            if (out_col == 0) keep &= ~9'h1C0;
            if (out_col >= w - 1) keep &= ~9'h007;
            if (out_row == 0) keep &= ~9'h049;
            if (out_row >= h - 1) keep &= ~9'h124;
            want.painted = !win_opacity[4] && ((win_opacity & keep) != 0);
            want.pixel = want.painted ? outline_reg : win_pixels[1];
            want.last = (out_row >= h - 1) && (out_col >= w - 1);
            expected_beats.push_back(want);

            if (want.last) begin
                out_row = 0;
                out_col = 0;
                in_row = 0;
                in_col = 0;
                draining = 1'b0;
                primed = 1'b0;
            end else if (out_col >= w - 1) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        endfunction

        // Compare one output beat against the oldest prediction.
        function void check_beat(logic [aout_pkg::PIX_W-1:0] pixel, logic painted,
                                 logic last);
            t_painted_beat want;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat, expected none, actual %08h",
                         $time, pixel);
                return;
            end
            want = expected_beats.pop_front();
            results_seen++;
            if (want.painted) painted_seen++;
            if (want.last) frames_done++;
            if (pixel !== want.pixel) begin
                errors++;
                $display("%0t: pixel_out expected %08h, actual %08h",
                         $time, want.pixel, pixel);
            end
            if (painted !== want.painted) begin
                errors++;
                $display("%0t: is_outline expected %0b, actual %0b",
                         $time, want.painted, painted);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last_of_frame expected %0b, actual %0b",
                         $time, want.last, last);
            end
        endfunction

    endclass

endpackage

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench of the 3x3 alpha outline filter
// Streams directed and random frames through the filter with random gaps on
// both sides, a long output stall and register changes between frames, and
// checks every output beat against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [aout_pkg::CFG_IDX_W-1:0]  cfg_idx = aout_pkg::CFG_IMAGE_WIDTH;
    logic [aout_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic [31:0]                     s_data = '0;
    logic [0:0]                      s_user = aout_pkg::OP_PIXEL;
    logic                            m_ready = 1'b0;

    logic                            s_axis_tready;
    logic                            m_axis_tvalid;
    logic [31:0]                     m_axis_tdata;
    logic [0:0]                      m_axis_tuser;
    logic                            m_axis_tlast;

    // Stimulus controls shared between processes.
    logic                            steady = 1'b0;
    logic                            heavy_frame = 1'b0;
    logic                            out_hold = 1'b0;

    // Frame geometry and mask most recently programmed.
    int                              cur_w;
    int                              cur_h;
    logic [31:0]                     cur_mask;
    int                              settings_used = 0;

    outline_tb_pkg::outline_scoreboard sb = new();

    alpha_outline_3x3 u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),         // [31:0] pixel_in
        .s_axis_tuser  (s_user),         // [0] op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] pixel_out
        .m_axis_tuser  (m_axis_tuser),   // [0] is_outline
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, none in steady stretches, stalled while held.
    always @(posedge clk) begin
        m_ready <= !out_hold && (steady || $urandom_range(99) >= 6);
    end

    // Check every accepted output beat.
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_ready)
            sb.check_beat(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
    end

    // Long output stall during the wide frame so the input side backs up.
    initial begin
        while (!heavy_frame) @(posedge clk);
        repeat (40) @(posedge clk);
        out_hold <= 1'b1;
        repeat (600) @(posedge clk);
        out_hold <= 1'b0;
    end

    // Watchdog.
    initial begin
        #4_000_000;
        $display("Timeout with %0d output beats still expected", sb.pending());
        $display("alpha_outline_3x3 regression: fail");
        $finish;
    end

    // Offer one input beat and wait until it is taken.
    task automatic send_beat(input logic op, input logic [31:0] pix);
        while (!steady && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= pix;
        s_user <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.take_beat(op, pix);
    endtask

    // Stop sending and let every pending result come out.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input aout_pkg::t_cfg_idx idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Program all four registers; bits above the register widths are junk.
    task automatic load_regs(input int w_reg, input int h_reg,
                             input logic [31:0] color, input logic [31:0] mask);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(aout_pkg::CFG_IMAGE_WIDTH, {junk[31:11], w_reg[10:0]});
        write_reg(aout_pkg::CFG_IMAGE_HEIGHT, {junk[18:0], h_reg[12:0]});
        write_reg(aout_pkg::CFG_OUTLINE, color);
        write_reg(aout_pkg::CFG_ALPHA_MASK, mask);
        cfg_we <= 1'b0;
        cur_w = (w_reg[10:0] == 0) ? 1 : (w_reg[10:0] > aout_pkg::MAX_WIDTH_DEF) ?
                aout_pkg::MAX_WIDTH_DEF : int'(w_reg[10:0]);
        cur_h = (h_reg[12:0] == 0) ? 1 : (h_reg[12:0] > aout_pkg::MAX_ROWS) ?
                aout_pkg::MAX_ROWS : int'(h_reg[12:0]);
        cur_mask = mask;
        settings_used++;
    endtask

    // Random pixel that is opaque with the given chance under the current mask.
    function automatic logic [31:0] make_pixel(input int opaque_pct);
        logic [31:0] pix;
        pix = $urandom();
        if ($urandom_range(99) < opaque_pct) begin
            if (cur_mask != 0 && (pix & cur_mask) == 0)
                pix |= cur_mask & (~cur_mask + 32'd1);
        end else begin
            pix &= ~cur_mask;
        end
        return pix;
    endfunction

    // One frame with its drain beats, salted with stray drains and with
    // pixels inside the drain phase.
    task automatic run_frame(input int w, input int h, input int opaque_pct,
                             input int noise_pct);
        for (int n = 0; n < w * h; n++) begin
            if ($urandom_range(99) < noise_pct)
                send_beat(aout_pkg::OP_DRAIN, $urandom());
            send_beat(aout_pkg::OP_PIXEL, make_pixel(opaque_pct));
        end
        for (int n = 0; n <= w; n++) begin
            if ($urandom_range(99) < noise_pct * 3)
                send_beat(aout_pkg::OP_PIXEL, $urandom());
            else
                send_beat(aout_pkg::OP_DRAIN, $urandom());
        end
        if ($urandom_range(99) < noise_pct * 3) send_beat(aout_pkg::OP_DRAIN, $urandom());
    endtask

    initial begin
        logic [31:0] grid [9];
        logic [31:0] mask;
        int          items;
        int          frame_no;
        int          w_reg;
        bit          need_cfg;

        grid = '{32'h0000_0000, 32'h00FF_FFFF, 32'h0000_0000,
                 32'h00AB_CDEF, 32'hFF00_0000, 32'h0012_3456,
                 32'hFFFF_FFFF, 32'h0000_0000, 32'h0100_0000};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame: a lone opaque center plus two corners, with stray drains
        // before the frame, in the middle of it and after its last result.
        load_regs(3, 3, 32'hFFFF_FFFF, 32'hFF00_0000);
        send_beat(aout_pkg::OP_DRAIN, 32'hDEAD_BEEF);
        for (int n = 0; n < 9; n++) begin
            if (n == 5) send_beat(aout_pkg::OP_DRAIN, '0);
            send_beat(aout_pkg::OP_PIXEL, grid[n]);
        end
        send_beat(aout_pkg::OP_DRAIN, '0);
        // A pixel inside the drain phase counts as a drain.
        send_beat(aout_pkg::OP_PIXEL, 32'hFFFF_FFFF);
        send_beat(aout_pkg::OP_DRAIN, '0);
        send_beat(aout_pkg::OP_DRAIN, '0);
        send_beat(aout_pkg::OP_DRAIN, 32'hFFFF_FFFF);
        wait_until_drained();

        // Single row frame: the first drain releases nothing.
        load_regs(4, 1, 32'h0000_0000, 32'hFF00_0000);
        send_beat(aout_pkg::OP_PIXEL, 32'h0000_0000);
        send_beat(aout_pkg::OP_PIXEL, 32'hFF00_0000);
        send_beat(aout_pkg::OP_PIXEL, 32'h00FF_FFFF);
        send_beat(aout_pkg::OP_PIXEL, 32'h0000_0001);
        for (int n = 0; n < 5; n++) send_beat(aout_pkg::OP_DRAIN, '0);
        wait_until_drained();

        // Zero width and height clamp to a 1x1 frame; a zero mask means opaque.
        load_regs(0, 0, 32'h1234_5678, 32'h0000_0000);
        send_beat(aout_pkg::OP_PIXEL, 32'h0000_0000);
        send_beat(aout_pkg::OP_DRAIN, '0);
        send_beat(aout_pkg::OP_DRAIN, '0);
        wait_until_drained();

        // Random frames, mostly small, with one wider frame that takes the
        // long output stall.
        items = 0;
        frame_no = 0;
        need_cfg = 1'b1;
        while (items < 1600) begin
            steady <= (frame_no >= 8 && frame_no < 20);
            if (frame_no == 4) begin
                wait_until_drained();
                load_regs(72, 3, $urandom(), 32'hFF00_0000);
                heavy_frame <= 1'b1;
                run_frame(cur_w, cur_h, 25, 0);
                need_cfg = 1'b1;
            end else begin
                if (need_cfg || $urandom_range(99) < 35) begin
                    wait_until_drained();
                    case ($urandom_range(5))
                        0: mask = 32'h0000_0000;
                        1: mask = 32'hFFFF_FFFF;
                        2: mask = 32'hFF00_0000;
                        3: mask = 32'h0000_00FF;
                        4: mask = 32'h1 << $urandom_range(31);
                        default: mask = $urandom();
                    endcase
                    w_reg = ($urandom_range(9) == 0) ? $urandom_range(17, 80) :
                            $urandom_range(1, 16);
                    if (w_reg == 1 && $urandom_range(1) == 0) w_reg = 0;
                    load_regs(w_reg, $urandom_range(1, 8), $urandom(), mask);
                    need_cfg = 1'b0;
                end
                run_frame(cur_w, cur_h, $urandom_range(4) * 25, 3);
            end
            items += cur_w * cur_h + cur_w + 1;
            frame_no++;
        end

        steady <= 1'b0;
        wait_until_drained();
        $display("Covered %0d frames over %0d register settings: %0d input beats,",
                 sb.frames_done, settings_used, sb.beats_taken);
        $display("%0d output beats checked, %0d of them painted with the outline.",
                 sb.results_seen, sb.painted_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("alpha_outline_3x3 regression: pass");
        else
            $display("alpha_outline_3x3 regression: fail");
        $finish;
    end

endmodule
